/* rtl/rbnp_pkg.sv */
// Shared types and constants for the nearest ray/box pick block.
// Holds the item words, config register codes, state codes and the
// command/status structs used between controller and datapath.
package rbnp_pkg;

  // Default fraction bits of the fixed-point coordinates
  localparam int FRAC_BITS_DEF = 16;

  localparam int COORD_W   = 32;
  localparam int ID_W      = 32;
  localparam int DIST_W    = 31;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_AXES  = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_DIR_X    = 3'd3,
    CFG_DIR_Y    = 3'd4,
    CFG_DIR_Z    = 3'd5
  } cfg_reg_e;

  // Input word: one box
  typedef struct packed {
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_z;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;
    logic [ID_W-1:0]           object_id;
    logic                      box_enabled;
    logic                      last_box;
  } box_t;

  // Result word: outcome of one pick
  typedef struct packed {
    logic              found;
    logic [ID_W-1:0]   selected_id;
    logic [DIST_W-1:0] hit_distance;
  } res_t;

  // Controller states, one-hot
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_START  = 7'b0000010,
    S_DIV    = 7'b0000100,
    S_SLAB   = 7'b0001000,
    S_PAIR   = 7'b0010000,
    S_MERGE  = 7'b0100000,
    S_DECIDE = 7'b1000000
  } rbnp_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_start;
    logic slab;
    logic pair;
    logic merge;
    logic decide;
  } rbnp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic last;
    logic out_busy;
  } rbnp_stat_t;

endpackage

/* rtl/rbnp_div.sv */
// Iterative restoring divider: (num << FRAC_BITS) / den, truncated toward zero.
// One quotient bit per cycle. Depends on rbnp_pkg.
module rbnp_div import rbnp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [32:0]       num_i,
  input  logic signed [31:0]       den_i,
  output logic                     busy_o,
  output logic signed [33+FRAC_BITS:0] quot_o
);

  localparam int QW = 33 + FRAC_BITS;
  localparam int TW = QW + 1;
  localparam int CW = $clog2(QW);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [QW-1:0] dvd_q;
  logic [31:0]   rem_q;
  logic [31:0]   dvs_q;
  logic          neg_q;

  logic [32:0]   mag_n;
  logic [32:0]   mag_d;
  logic [32:0]   rem_sh;
  logic [33:0]   diff;
  logic          ge;
  logic [TW-1:0] q_pos;

  // operand magnitudes
  always_comb begin
    mag_n = num_i[32] ? (33'd0 - num_i) : num_i;
    mag_d = den_i[31] ? (33'd0 - {den_i[31], den_i}) : {1'b0, den_i};
  end

  // one restoring step
  always_comb begin
    rem_sh = {rem_q, dvd_q[QW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
    ge     = ~diff[33];
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(QW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  // dividend shifts out at the top, quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {mag_n, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      dvs_q <= mag_d[31:0];
      neg_q <= num_i[32] ^ den_i[31];
    end else if (busy_q) begin
      dvd_q <= {dvd_q[QW-2:0], ge};
      rem_q <= ge ? diff[31:0] : rem_sh[31:0];
    end
  end

  // apply sign
  assign q_pos  = {1'b0, dvd_q};
  assign quot_o = neg_q ? (TW'(0) - q_pos) : q_pos;
  assign busy_o = busy_q;

endmodule

/* rtl/rbnp_datapath.sv */
// Datapath: ray registers, box capture, six slab dividers, entry/exit merge
// and the nearest-hit tracker with its result register. Depends on rbnp_pkg.
module rbnp_datapath import rbnp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  input  box_t                 box_i,
  output logic                 res_valid_o,
  input  logic                 res_stall_i,
  output res_t                 res_o,
  input  rbnp_cmd_t            cmd_i,
  output rbnp_stat_t           stat_o
);

  localparam int QW = 33 + FRAC_BITS;
  localparam int TW = QW + 1;
  localparam logic signed [TW-1:0] T_ZERO = '0;
  localparam logic signed [TW-1:0] T_INF  = {1'b0, {(TW-1){1'b1}}};

  logic signed [COORD_W-1:0] org_q [NUM_AXES];
  logic signed [COORD_W-1:0] dir_q [NUM_AXES];
  box_t                      box_q;

  logic signed [COORD_W-1:0] lo [NUM_AXES];
  logic signed [COORD_W-1:0] hi [NUM_AXES];
  logic signed [32:0]        num_lo [NUM_AXES];
  logic signed [32:0]        num_hi [NUM_AXES];
  logic signed [TW-1:0]      t_lo [NUM_AXES];
  logic signed [TW-1:0]      t_hi [NUM_AXES];
  logic [NUM_AXES-1:0]       busy_lo;
  logic [NUM_AXES-1:0]       busy_hi;
  logic [NUM_AXES-1:0]       par_miss;

  logic signed [TW-1:0]      ent_q [NUM_AXES];
  logic signed [TW-1:0]      ext_q [NUM_AXES];
  logic                      par_miss_q;
  logic signed [TW-1:0]      n01_q, n2_q, f01_q, f2_q;
  logic signed [TW-1:0]      near_q, far_q;

  logic                      hit_seen_q;
  logic [ID_W-1:0]           best_id_q;
  logic [DIST_W-1:0]         best_dist_q;
  logic                      res_valid_q;
  res_t                      res_q;

  logic                      hit;
  logic [DIST_W-1:0]         box_dist;
  logic                      take;
  logic                      nxt_seen;
  logic [ID_W-1:0]           nxt_id;
  logic [DIST_W-1:0]         nxt_dist;

  // ray registers, written through the config port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        org_q[a] <= '0;
        dir_q[a] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ORIGIN_X: org_q[0] <= cfg_data_i;
        CFG_ORIGIN_Y: org_q[1] <= cfg_data_i;
        CFG_ORIGIN_Z: org_q[2] <= cfg_data_i;
        CFG_DIR_X:    dir_q[0] <= cfg_data_i;
        CFG_DIR_Y:    dir_q[1] <= cfg_data_i;
        CFG_DIR_Z:    dir_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // box capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      box_q <= box_i;
    end
  end

  // per-axis slab numerators and parallel-axis misses
  always_comb begin
    lo[0] = box_q.box_min_x;
    lo[1] = box_q.box_min_y;
    lo[2] = box_q.box_min_z;
    hi[0] = box_q.box_max_x;
    hi[1] = box_q.box_max_y;
    hi[2] = box_q.box_max_z;
    for (int a = 0; a < NUM_AXES; a++) begin
      num_lo[a]   = {lo[a][COORD_W-1], lo[a]} - {org_q[a][COORD_W-1], org_q[a]};
      num_hi[a]   = {hi[a][COORD_W-1], hi[a]} - {org_q[a][COORD_W-1], org_q[a]};
      par_miss[a] = (dir_q[a] == '0) && ((org_q[a] < lo[a]) || (org_q[a] > hi[a]));
    end
  end

  // six dividers, all started together
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    rbnp_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (cmd_i.div_start),
      .num_i   (num_lo[a]),
      .den_i   (dir_q[a]),
      .busy_o  (busy_lo[a]),
      .quot_o  (t_lo[a])
    );
    rbnp_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (cmd_i.div_start),
      .num_i   (num_hi[a]),
      .den_i   (dir_q[a]),
      .busy_o  (busy_hi[a]),
      .quot_o  (t_hi[a])
    );
  end

  // order entry/exit per axis; parallel axes impose no limit
  always_ff @(posedge clk_i) begin
    if (cmd_i.slab) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (dir_q[a] == '0) begin
          ent_q[a] <= T_ZERO;
          ext_q[a] <= T_INF;
        end else if (t_lo[a] > t_hi[a]) begin
          ent_q[a] <= t_hi[a];
          ext_q[a] <= t_lo[a];
        end else begin
          ent_q[a] <= t_lo[a];
          ext_q[a] <= t_hi[a];
        end
      end
      par_miss_q <= |par_miss;
    end
  end

  // near/far reduction in two steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.pair) begin
      n01_q <= (ent_q[0] > ent_q[1]) ? ent_q[0] : ent_q[1];
      n2_q  <= (ent_q[2] > T_ZERO) ? ent_q[2] : T_ZERO;
      f01_q <= (ext_q[0] < ext_q[1]) ? ext_q[0] : ext_q[1];
      f2_q  <= ext_q[2];
    end
    if (cmd_i.merge) begin
      near_q <= (n01_q > n2_q) ? n01_q : n2_q;
      far_q  <= (f01_q < f2_q) ? f01_q : f2_q;
    end
  end

  // hit decision and best-so-far update
  always_comb begin
    hit      = box_q.box_enabled && !par_miss_q && (near_q <= far_q) && !far_q[TW-1];
    box_dist = (|near_q[TW-1:DIST_W]) ? {DIST_W{1'b1}} : near_q[DIST_W-1:0];
    take     = hit && (!hit_seen_q || (box_dist < best_dist_q));
    nxt_seen = hit_seen_q | take;
    nxt_id   = take ? box_q.object_id : best_id_q;
    nxt_dist = take ? box_dist : best_dist_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_seen_q  <= 1'b0;
      best_id_q   <= '0;
      best_dist_q <= '1;
    end else if (cmd_i.decide) begin
      if (box_q.last_box) begin
        hit_seen_q  <= 1'b0;
        best_id_q   <= '0;
        best_dist_q <= '1;
      end else begin
        hit_seen_q  <= nxt_seen;
        best_id_q   <= nxt_id;
        best_dist_q <= nxt_dist;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.decide && box_q.last_box) begin
      res_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && box_q.last_box) begin
      res_q.found        <= nxt_seen;
      res_q.selected_id  <= nxt_seen ? nxt_id : '0;
      res_q.hit_distance <= nxt_seen ? nxt_dist : '0;
    end
  end

  assign res_valid_o     = res_valid_q;
  assign res_o           = res_q;
  assign stat_o.div_done = ~|{busy_lo, busy_hi};
  assign stat_o.last     = box_q.last_box;
  assign stat_o.out_busy = res_valid_q && res_stall_i;

`ifndef SYNTHESIS
  // an empty tracker carries its cleared values
  a_clear_tracker : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hit_seen_q |-> (best_id_q == '0) && (best_dist_q == '1))
    else $error("tracker holds data without a hit");

  // a miss result carries zero id and distance
  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.found |-> (res_q.selected_id == '0) && (res_q.hit_distance == '0))
    else $error("miss result with nonzero fields");
`endif

endmodule

/* rtl/rbnp_ctrl.sv */
// Controller state machine: box acceptance, divider start, merge steps and
// the decide step, which for a closing box is held while a finished result is still stalled. Uses rbnp_pkg.
module rbnp_ctrl import rbnp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       box_valid_i,
  output logic       box_stall_o,
  input  rbnp_stat_t stat_i,
  output rbnp_cmd_t  cmd_o
);

  rbnp_state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (box_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_SLAB;
        end
      end
      S_SLAB: begin
        cmd_o.slab = 1'b1;
        state_d    = S_PAIR;
      end
      S_PAIR: begin
        cmd_o.pair = 1'b1;
        state_d    = S_MERGE;
      end
      S_MERGE: begin
        cmd_o.merge = 1'b1;
        state_d     = S_DECIDE;
      end
      S_DECIDE: begin
        // the closing box waits for the result register to drain
        if (!(stat_i.last && stat_i.out_busy)) begin
          cmd_o.decide = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign box_stall_o = (state_q != S_IDLE);

`ifndef SYNTHESIS
  // the slab step only follows finished division
  a_div_exit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) && (state_d != S_DIV) |-> stat_i.div_done)
    else $error("left division before dividers finished");

  // a result is never written over one still stalled
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.decide && stat_i.last |-> !stat_i.out_busy)
    else $error("result register overwritten while stalled");
`endif

endmodule

/* rtl/ray_box_nearest_pick.sv */
// Nearest ray/box pick: a box is not accepted until the previous one has been
// divided, reduced and decided; the result word becomes valid once its closing
// box has passed the decide step. The pace is set by the six restoring dividers,
// one quotient bit per cycle over FRAC_BITS+33 bits.
// Asynchronous active-low reset clears the ray to zero and empties the tracker.
module ray_box_nearest_pick import rbnp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  input  logic                 box_valid_i,
  output logic                 box_stall_o,
  input  box_t                 box_i,
  output logic                 res_valid_o,
  input  logic                 res_stall_i,
  output res_t                 res_o
);

  rbnp_cmd_t  cmd;
  rbnp_stat_t stat;

  // sequencing
  rbnp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .box_valid_i (box_valid_i),
    .box_stall_o (box_stall_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // arithmetic and storage
  rbnp_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .box_i       (box_i),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .res_o       (res_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

/* test/ray_box_nearest_pick_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for ray_box_nearest_pick: directed table, then random picks.
// Needs rbnp_pkg and the block; expected pick outcomes come from a local slab-test model, or from the table row.

module ray_box_nearest_pick_test;
  import rbnp_pkg::*;

  localparam int FRAC_BITS   = FRAC_BITS_DEF;
  localparam int LATENCY     = FRAC_BITS + 44;
  localparam int NUM_REGS    = int'(CFG_DIR_Z) + 1;
  localparam int IDLE_PCT    = 31;
  localparam int RAND_ITEMS  = 1750;
  localparam int NUM_SEGS    = 12;
  localparam int HOLD_SEG    = 4;
  localparam int CALM_SEG    = 6;
  localparam int HOLD_CYCLES = 1200;
  localparam int MAX_REPORTS = 10;
  localparam int TIMEOUT_NS  = 4_000_000;

  // Q16.16 handy values
  localparam logic [31:0] ONE     = 32'h0001_0000;
  localparam logic [31:0] NEG_ONE = 32'hFFFF_0000;
  localparam logic [31:0] HALF    = 32'h0000_8000;
  localparam logic [31:0] MIN_W   = 32'h8000_0000;
  localparam logic [31:0] MAX_W   = 32'h7FFF_FFFF;

  localparam int unsigned SPREAD   = 32'h0020_0000;
  localparam int unsigned HALF_MAX = 32'h0010_0000;
  localparam int unsigned DIR_SPAN = 32'h0004_0000;

  localparam longint DIST_SAT = 64'h0000_0000_7FFF_FFFF;
  localparam longint T_FAR    = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum int {RAY_NEAR, RAY_AXIS, RAY_WILD, RAY_EXTREME} ray_mode_e;

  typedef struct {
    int   sel;
    box_t box;
    bit   typed;
    res_t res;
  } row_t;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  cfg_reg_e       cfg_index_i = CFG_ORIGIN_X;
  logic [31:0]    cfg_data_i  = '0;
  logic           box_valid_i = 1'b0;
  logic           box_stall_o;
  box_t           box_i       = '0;
  logic           res_valid_o;
  logic           res_stall_i = 1'b0;
  res_t           res_o;

  // typed expectation travels alongside the box word
  bit             typed_on    = 1'b0;
  res_t           typed_res   = '0;

  // model state: ray and running pick
  logic [5:0][31:0]  ray_now   = '0;
  bit                pick_hit  = 1'b0;
  logic [ID_W-1:0]   pick_id   = '0;
  logic [DIST_W-1:0] pick_dist = '1;
  res_t              pick_outcomes_q [$];

  bit   calm       = 1'b0;
  int   hold_req   = 0;
  int   hold_ack   = 0;
  int   hold_left  = 0;
  int   mismatches = 0;
  int   boxes_taken = 0;
  int   picks_checked = 0;
  int   sent_boxes = 0;
  int   ray_loads  = 0;

  row_t             rows [$];
  logic [5:0][31:0] ray_tab [4];

  always #2 clk_i = ~clk_i;

  ray_box_nearest_pick dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .box_valid_i (box_valid_i),
    .box_stall_o (box_stall_o),
    .box_i       (box_i),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .res_o       (res_o)
  );

  // ((num << FRAC_BITS) / den), truncated toward zero
  function automatic longint slab_quot(longint num, longint den);
    longint unsigned mag_n, mag_d, q;
    mag_n = (num < 0) ? -num : num;
    mag_d = (den < 0) ? -den : den;
    q = (mag_n << FRAC_BITS) / mag_d;
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // slab test of one box against the current ray
  function automatic bit slab_hit(box_t b, output logic [DIST_W-1:0] near_dist);
    longint lo [NUM_AXES];
    longint hi [NUM_AXES];
    longint org, dir, t1, t2, swap, near_t, far_t;
    bit     hit;
    lo[0] = longint'($signed(b.box_min_x));
    lo[1] = longint'($signed(b.box_min_y));
    lo[2] = longint'($signed(b.box_min_z));
    hi[0] = longint'($signed(b.box_max_x));
    hi[1] = longint'($signed(b.box_max_y));
    hi[2] = longint'($signed(b.box_max_z));
    near_t = 0;
    far_t  = T_FAR;
    hit    = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      org = longint'($signed(ray_now[int'(CFG_ORIGIN_X) + a]));
      dir = longint'($signed(ray_now[int'(CFG_DIR_X) + a]));
      if (hit) begin
        if (dir == 0) begin
          // parallel: only the slab containment matters
          if (org < lo[a] || org > hi[a]) hit = 1'b0;
        end else begin
          t1 = slab_quot(lo[a] - org, dir);
          t2 = slab_quot(hi[a] - org, dir);
          if (t1 > t2) begin
            swap = t1;
            t1   = t2;
            t2   = swap;
          end
          if (t1 > near_t) near_t = t1;
          if (t2 < far_t) far_t = t2;
          if (near_t > far_t) hit = 1'b0;
        end
      end
    end
    if (far_t < 0) hit = 1'b0;
    near_dist = (near_t > DIST_SAT) ? '1 : near_t[DIST_W-1:0];
    return hit;
  endfunction

  // fold an accepted box into the pick; closing box queues the outcome
  task automatic fold_box(box_t b);
    logic [DIST_W-1:0] d;
    res_t              want;
    if (b.box_enabled) begin
      if (slab_hit(b, d) && (!pick_hit || d < pick_dist)) begin
        pick_dist = d;
        pick_id   = b.object_id;
        pick_hit  = 1'b1;
      end
    end
    if (b.last_box) begin
      want = '0;
      if (pick_hit) begin
        want.found        = 1'b1;
        want.selected_id  = pick_id;
        want.hit_distance = pick_dist;
      end
      if (typed_on) want = typed_res;
      pick_outcomes_q.push_back(want);
      pick_hit  = 1'b0;
      pick_id   = '0;
      pick_dist = '1;
    end
    boxes_taken++;
  endtask

  task automatic mismatch(string what, res_t want, res_t got);
    if (mismatches < MAX_REPORTS)
      $display("%0t %s: expected found=%0d id=%h dist=%h, got found=%0d id=%h dist=%h",
               $time, what, want.found, want.selected_id, want.hit_distance,
               got.found, got.selected_id, got.hit_distance);
    mismatches++;
  endtask

  task automatic check_pick(res_t got);
    res_t want;
    picks_checked++;
    if (pick_outcomes_q.size() == 0) begin
      mismatch("result word with nothing expected", '0, got);
    end else begin
      want = pick_outcomes_q.pop_front();
      if (got.found !== want.found || got.selected_id !== want.selected_id ||
          got.hit_distance !== want.hit_distance)
        mismatch("pick outcome differs", want, got);
    end
  endtask

  // observe every handshake on the edge it completes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) ray_now[cfg_index_i] = cfg_data_i;
      if (box_valid_i && !box_stall_o) fold_box(box_i);
      if (res_valid_o && !res_stall_i) check_pick(res_o);
    end
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_stall_i <= 1'b1;
    end else begin
      res_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  function automatic box_t mk_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                                  logic [31:0] hx, logic [31:0] hy, logic [31:0] hz,
                                  logic [31:0] id, bit en, bit last);
    box_t b;
    b.box_min_x   = lx;
    b.box_min_y   = ly;
    b.box_min_z   = lz;
    b.box_max_x   = hx;
    b.box_max_y   = hy;
    b.box_max_z   = hz;
    b.object_id   = id;
    b.box_enabled = en;
    b.last_box    = last;
    return b;
  endfunction

  function automatic res_t mk_res(bit found, logic [ID_W-1:0] id, logic [DIST_W-1:0] dist_v);
    res_t r;
    r.found        = found;
    r.selected_id  = id;
    r.hit_distance = dist_v;
    return r;
  endfunction

  function automatic logic [5:0][31:0] mk_ray(logic [31:0] ox, logic [31:0] oy,
                                              logic [31:0] oz, logic [31:0] dx,
                                              logic [31:0] dy, logic [31:0] dz);
    logic [5:0][31:0] w;
    w[CFG_ORIGIN_X] = ox;
    w[CFG_ORIGIN_Y] = oy;
    w[CFG_ORIGIN_Z] = oz;
    w[CFG_DIR_X]    = dx;
    w[CFG_DIR_Y]    = dy;
    w[CFG_DIR_Z]    = dz;
    return w;
  endfunction

  task automatic add_row(int sel, box_t b, bit typed, res_t r);
    row_t row;
    row.sel   = sel;
    row.box   = b;
    row.typed = typed;
    row.res   = r;
    rows.push_back(row);
  endtask

  function automatic logic [31:0] rnd_q(int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [31:0] extreme_word();
    case ($urandom_range(0, 4))
      0:       return MIN_W;
      1:       return MAX_W;
      2:       return '0;
      3:       return 32'h1;
      default: return '1;
    endcase
  endfunction

  function automatic logic [5:0][31:0] pick_ray(ray_mode_e mode);
    logic [5:0][31:0] w;
    int               solo;
    int               o, d;
    solo = $urandom_range(0, NUM_AXES - 1);
    for (int a = 0; a < NUM_AXES; a++) begin
      o = int'(CFG_ORIGIN_X) + a;
      d = int'(CFG_DIR_X) + a;
      case (mode)
        RAY_NEAR: begin
          w[o] = rnd_q(SPREAD / 2);
          w[d] = ($urandom_range(0, 3) == 0) ? '0 : rnd_q(DIR_SPAN);
        end
        RAY_AXIS: begin
          w[o] = rnd_q(SPREAD / 2);
          w[d] = (a == solo) ? rnd_q(DIR_SPAN) : '0;
        end
        RAY_WILD: begin
          w[o] = $urandom;
          w[d] = $urandom;
        end
        default: begin
          w[o] = extreme_word();
          w[d] = extreme_word();
        end
      endcase
    end
    return w;
  endfunction

  // half the boxes placed on the ray path, the rest scattered, some noise or inverted
  function automatic box_t rand_box(logic [5:0][31:0] ray, bit last);
    logic [31:0] lo [NUM_AXES];
    logic [31:0] hi [NUM_AXES];
    logic [31:0] p;
    int          kind;
    int unsigned k;
    kind = $urandom_range(0, 99);
    k    = $urandom_range(0, 12);
    for (int a = 0; a < NUM_AXES; a++) begin
      if (kind < 50) p = ray[int'(CFG_ORIGIN_X) + a] + ray[int'(CFG_DIR_X) + a] * k;
      else p = rnd_q(SPREAD);
      lo[a] = p - $urandom_range(0, HALF_MAX);
      hi[a] = p + $urandom_range(0, HALF_MAX);
      if (kind >= 80 && kind < 90) begin
        lo[a] = $urandom;
        hi[a] = $urandom;
      end
      if (kind >= 90 && a == 0) begin
        lo[a] = p + 1 + $urandom_range(0, HALF_MAX);
        hi[a] = p;
      end
    end
    return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], $urandom,
                  $urandom_range(0, 9) != 0, last);
  endfunction

  // offer one box word, with an occasional gap first
  task automatic send_box(box_t b, bit typed, res_t tres);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      box_valid_i <= 1'b0;
      repeat ($urandom_range(1, 70)) @(posedge clk_i);
    end
    box_i       <= b;
    typed_on    <= typed;
    typed_res   <= tres;
    box_valid_i <= 1'b1;
    @(posedge clk_i);
    while (box_stall_o) @(posedge clk_i);
    sent_boxes++;
  endtask

  // hold the sender until every pick is out and the block has gone quiet
  task automatic wait_for_quiet();
    box_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pick_outcomes_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic program_ray(logic [5:0][31:0] words);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_index_i <= cfg_reg_e'(i);
      cfg_data_i  <= words[i];
      cfg_valid_i <= 1'b1;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    ray_loads++;
  endtask

  // main sequence
  initial begin
    ray_mode_e        mode;
    logic [5:0][31:0] ray;
    int               cur_sel;
    int               quota;
    int               len;

    ray_tab[0] = '0;
    ray_tab[1] = mk_ray(32'hFFF6_0000, HALF, HALF, ONE, '0, '0);
    ray_tab[2] = mk_ray(MIN_W, MIN_W, MIN_W, 32'h1, '0, '0);
    ray_tab[3] = mk_ray(MAX_W, MAX_W, MAX_W, MIN_W, MIN_W, MIN_W);

    // ray straight after reset: all parallel, origin at zero
    add_row(0, mk_box(NEG_ONE, NEG_ONE, NEG_ONE, ONE, ONE, ONE, 32'h11, 1, 1), 1,
            mk_res(1, 32'h11, '0));
    add_row(0, mk_box(ONE, NEG_ONE, NEG_ONE, 32'h0002_0000, ONE, ONE, 32'h12, 1, 1), 1, '0);
    add_row(0, mk_box(NEG_ONE, NEG_ONE, NEG_ONE, ONE, ONE, ONE, 32'h13, 0, 1), 1, '0);
    add_row(0, mk_box(MIN_W, MIN_W, MIN_W, MAX_W, MAX_W, MAX_W, '1, 1, 1), 1,
            mk_res(1, '1, '0));
    add_row(0, mk_box(ONE, ONE, ONE, NEG_ONE, NEG_ONE, NEG_ONE, 32'h3, 1, 1), 1, '0);
    add_row(0, mk_box('0, '0, '0, '0, '0, '0, '0, 1, 1), 1, mk_res(1, '0, '0));
    // equal distances: first hit stays
    add_row(0, mk_box(NEG_ONE, NEG_ONE, NEG_ONE, ONE, ONE, ONE, 32'h5, 1, 0), 0, '0);
    add_row(0, mk_box(NEG_ONE, NEG_ONE, NEG_ONE, ONE, ONE, ONE, 32'h6, 1, 1), 1,
            mk_res(1, 32'h5, '0));
    // disabled closing box still ends the pick
    add_row(0, mk_box(NEG_ONE, NEG_ONE, NEG_ONE, ONE, ONE, ONE, 32'h7, 1, 0), 0, '0);
    add_row(0, mk_box(NEG_ONE, NEG_ONE, NEG_ONE, ONE, ONE, ONE, 32'h8, 0, 1), 1,
            mk_res(1, 32'h7, '0));
    // ray from x = -10 along +x
    add_row(1, mk_box('0, '0, '0, ONE, ONE, ONE, 32'h21, 1, 1), 1,
            mk_res(1, 32'h21, 31'h000A_0000));
    add_row(1, mk_box(32'hFFEC_0000, '0, '0, 32'hFFF1_0000, ONE, ONE, 32'h22, 1, 0), 0, '0);
    add_row(1, mk_box(32'h0004_0000, '0, '0, 32'h0006_0000, ONE, ONE, 32'h23, 1, 0), 0, '0);
    add_row(1, mk_box(32'hFFF4_0000, '0, '0, 32'h0002_0000, ONE, ONE, 32'h24, 1, 1), 0, '0);
    add_row(1, mk_box('0, ONE, '0, ONE, 32'h0002_0000, ONE, 32'h25, 1, 1), 0, '0);
    add_row(1, mk_box('0, '0, '0, ONE, HALF, ONE, 32'h26, 1, 1), 0, '0);
    // tiny direction: distance saturates, equal saturated hit does not replace
    add_row(2, mk_box(32'h7FFF_0000, MIN_W, MIN_W, MAX_W, '0, '0, 32'h31, 1, 0), 0, '0);
    add_row(2, mk_box(32'h7FFF_0000, MIN_W, MIN_W, MAX_W, '0, '0, 32'h32, 1, 1), 1,
            mk_res(1, 32'h31, '1));
    // extreme origin and most negative direction
    add_row(3, mk_box(MIN_W, MIN_W, MIN_W, MAX_W, MAX_W, MAX_W, 32'h41, 1, 1), 0, '0);
    add_row(3, mk_box('0, '0, '0, ONE, ONE, ONE, 32'h42, 1, 1), 0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table
    cur_sel = 0;
    foreach (rows[i]) begin
      if (rows[i].sel != cur_sel) begin
        wait_for_quiet();
        program_ray(ray_tab[rows[i].sel]);
        cur_sel = rows[i].sel;
      end
      send_box(rows[i].box, rows[i].typed, rows[i].res);
    end

    // random picks, a fresh ray per segment
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      wait_for_quiet();
      if (seg % 3 == 2) mode = ((seg / 3) % 2 == 0) ? RAY_WILD : RAY_EXTREME;
      else mode = (seg % 3 == 0) ? RAY_NEAR : RAY_AXIS;
      ray = pick_ray(mode);
      program_ray(ray);
      calm = (seg == CALM_SEG);
      if (seg == HOLD_SEG) hold_req++;
      quota = sent_boxes + RAND_ITEMS / NUM_SEGS;
      while (sent_boxes < quota) begin
        len = $urandom_range(1, (seg == HOLD_SEG) ? 1 : 8);
        for (int j = 0; j < len; j++) send_box(rand_box(ray, j == len - 1), 1'b0, '0);
      end
    end
    calm = 1'b0;
    wait_for_quiet();

    $display("covered %0d boxes and %0d picks over %0d ray settings", boxes_taken,
             picks_checked, ray_loads + 1);
    $display("included a long result hold-off, a stall-free stretch and %0d mismatches",
             mismatches);
    if (mismatches == 0 && pick_outcomes_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d picks outstanding", pick_outcomes_q.size());
    $display("status: fail");
    $finish;
  end

endmodule

/* ray_box_nearest_pick.f */
rtl/rbnp_pkg.sv
rtl/rbnp_div.sv
rtl/rbnp_datapath.sv
rtl/rbnp_ctrl.sv
rtl/ray_box_nearest_pick.sv
test/ray_box_nearest_pick_test.sv
